/* rtl/ambt_pkg.sv */
package ambt_pkg;

  // fixed field widths of the transactions
  localparam int PRED_BITS      = 12;
  localparam int VAR_BITS       = 10;
  localparam int ELEM_BITS      = 16;
  localparam int COUNT_OUT_BITS = 7;

  // input transaction: one argument pair of an atom
  typedef struct packed {
    logic                 clear_before;
    logic                 first_of_atom;
    logic                 last_of_atom;
    logic [PRED_BITS-1:0] pattern_predicate;
    logic [PRED_BITS-1:0] ground_predicate;
    logic                 has_argument;
    logic [VAR_BITS-1:0]  variable_index;
    logic [ELEM_BITS-1:0] element_value;
  } item_t;

  // result transaction: one per finished atom
  typedef struct packed {
    logic                      matched;
    logic [COUNT_OUT_BITS-1:0] binding_count;
    logic                      table_overflow;
  } result_t;

  // one binding of the table
  typedef struct packed {
    logic [VAR_BITS-1:0]  variable;
    logic [ELEM_BITS-1:0] element;
  } entry_t;

endpackage

/* rtl/atom_match_binding_table_top.sv */
// Atom matcher with a variable-to-element binding table.
// Input channel: a transaction (item) is taken at a rising edge where start
// is high and busy is low. Each item carries one variable/element pair of
// an atom, with flags for the first and last pair and for clearing the table.
// Result channel: done is high for exactly one cycle with result valid; only
// items that end an atom produce a result. The receiver cannot stall, so a
// result is shown once and never held.
// Sequencing: an item without a pair, or one of an atom that already failed,
// gives its result in the cycle after acceptance and leaves busy low. An item
// with a pair searches the table from its oldest entry through the single
// registered read port of the table memory, one entry per cycle, and ends
// on a hit or with the final compare or append. Busy is high while it
// searches, and done and result are registered from its last search cycle.
// Reset (synchronous, active high) empties the table count and clears the
// failure and overflow flags; table contents need no clearing pass because
// only entries below the count are ever read.
module atom_match_binding_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ambt_pkg::item_t   item,
  output logic              done,
  output ambt_pkg::result_t result
);
  import ambt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        entry_count, entry_count_next;
  logic                 atom_failed, atom_failed_next;
  logic                 overflow_seen, overflow_seen_next;
  logic [CW-1:0]        addr, addr_next;
  logic                 cmp_valid, cmp_valid_next;
  logic                 done_next;
  result_t              result_next;

  logic [VAR_BITS-1:0]  var_q;
  logic [ELEM_BITS-1:0] elem_q;
  logic                 last_q;

  logic                 we, re, finish, last_sel, hit;
  entry_t               wdata, rdata;

  ambt_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (entry_count[AW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (addr[AW-1:0]),
    .rdata (rdata)
  );

  assign wdata.variable = var_q;
  assign wdata.element  = elem_q;
  assign busy           = (state == ST_SEARCH);

  // shared compare of the entry just read against the item's variable
  assign hit = cmp_valid && (rdata.variable == var_q);

  // sequencer
  always_comb begin
    state_next         = state;
    entry_count_next   = entry_count;
    atom_failed_next   = atom_failed;
    overflow_seen_next = overflow_seen;
    addr_next          = addr;
    cmp_valid_next     = cmp_valid;
    we                 = 1'b0;
    re                 = 1'b0;
    finish             = 1'b0;
    last_sel           = last_q;
    unique case (state)
      ST_IDLE: begin
        last_sel = item.last_of_atom;
        if (start) begin
          if (item.clear_before) begin
            entry_count_next = '0;
          end
          if (item.first_of_atom) begin
            atom_failed_next   = (item.pattern_predicate != item.ground_predicate);
            overflow_seen_next = 1'b0;
          end
          addr_next      = '0;
          cmp_valid_next = 1'b0;
          if (item.has_argument && !atom_failed_next) begin
            state_next = ST_SEARCH;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          if (rdata.element != elem_q) begin
            atom_failed_next = 1'b1;
          end
          finish     = 1'b1;
          state_next = ST_IDLE;
        end else if (addr == entry_count) begin
          // variable unbound: append or flag overflow
          if (entry_count < CW'(TABLE_DEPTH)) begin
            we               = 1'b1;
            entry_count_next = entry_count + CW'(1);
          end else begin
            overflow_seen_next = 1'b1;
            atom_failed_next   = 1'b1;
          end
          finish     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          re             = 1'b1;
          addr_next      = addr + CW'(1);
          cmp_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result of the item that finishes this cycle
  always_comb begin
    done_next                  = finish && last_sel;
    result_next.matched        = !atom_failed_next;
    result_next.binding_count  = COUNT_OUT_BITS'(entry_count_next);
    result_next.table_overflow = overflow_seen_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      atom_failed   <= 1'b0;
      overflow_seen <= 1'b0;
      addr          <= '0;
      cmp_valid     <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      atom_failed   <= atom_failed_next;
      overflow_seen <= overflow_seen_next;
      addr          <= addr_next;
      cmp_valid     <= cmp_valid_next;
      done          <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= result_next;
    if (start && !busy) begin
      var_q  <= item.variable_index;
      elem_q <= item.element_value;
      last_q <= item.last_of_atom;
    end
  end

endmodule

/* rtl/ambt_table.sv */
module ambt_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ambt_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output ambt_pkg::entry_t rdata
);
  import ambt_pkg::*;

  entry_t mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ambt_checker.sv */
module ambt_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input ambt_pkg::item_t   item,
  input logic              done,
  input ambt_pkg::result_t result
);
  import ambt_pkg::*;

  // an overflow always fails the atom
  a_overflow_fails: assert property (@(posedge clk) disable iff (rst)
    done && result.table_overflow |-> !result.matched)
    else $error("overflow reported on a matched atom");

  // an item without a pair needs no search
  a_no_pair_no_search: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.has_argument |=> !busy && (done == $past(item.last_of_atom)))
    else $error("item without a pair did not finish at once");

  // a result right after acceptance belongs to that item, which must end an atom
  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.last_of_atom |=> !done)
    else $error("result for an item that does not end an atom");

  // a single-item atom with differing predicates fails at once
  a_pred_mismatch: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.first_of_atom && item.last_of_atom &&
    (item.pattern_predicate != item.ground_predicate) |=> done && !result.matched)
    else $error("predicate mismatch not reported as failure");

endmodule

bind atom_match_binding_table_top ambt_checker u_ambt_checker (.*);
